>>> sv/sbsp_pkg.sv
// Shared types, constants and divider step functions for the sample point unit.
`default_nettype none
package sbsp_pkg;

  localparam int FRAC_BITS   = 5;
  localparam int DIM_W       = 16;
  localparam int DEN_W       = DIM_W + 1;
  localparam int NUM_W       = 2 * DIM_W + 1 + FRAC_BITS;
  localparam int QUO_W       = 22;
  localparam int QSTAGES     = QUO_W / 2;
  localparam int SSTAGES     = DIM_W / 2;
  localparam int QUEUE_DEPTH = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH = 2'd2;

  localparam logic [DIM_W-1:0] RST_SOURCE_LENGTH = 16'd128;
  localparam logic [DIM_W-1:0] RST_SCALE_FACTOR  = 16'd1;
  localparam logic [DIM_W-1:0] RST_TARGET_LENGTH = 16'd128;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CONFIG = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX  = 2'd2;

  localparam logic [QUO_W-1:0] STEP_HALF = QUO_W'(1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DIM_W-1:0] vsize;
    logic [DIM_W-1:0] scl;
  } front_t;

  typedef struct packed {
    logic [DIM_W-1:0] near_index;
    logic [DIM_W-1:0] far_index;
    logic [4:0]       blend_weight;
    logic [1:0]       status;
  } res_t;

  // one restoring step on the position divide: {quotient bit, new remainder}
  function automatic logic [DEN_W:0] qstep(input logic [DEN_W-1:0] rem, input logic b,
                                            input logic [DEN_W-1:0] den);
    logic [DEN_W:0] r;
    r = {rem, b};
    if (r >= {1'b0, den}) begin
      r = r - {1'b0, den};
      return {1'b1, r[DEN_W-1:0]};
    end
    return {1'b0, r[DEN_W-1:0]};
  endfunction

  // one restoring step on the scale divide
  function automatic logic [DIM_W:0] sstep(input logic [DIM_W-1:0] rem, input logic b,
                                            input logic [DIM_W-1:0] den);
    logic [DIM_W:0] r;
    r = {rem, b};
    if (r >= {1'b0, den}) begin
      r = r - {1'b0, den};
      return {1'b1, r[DIM_W-1:0]};
    end
    return {1'b0, r[DIM_W-1:0]};
  endfunction

endpackage
`default_nettype wire

>>> sv/sbsp_front.sv
// Front end: configuration registers, classification and numerator product.
`default_nettype none
module sbsp_front
  import sbsp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata,
  input  wire logic                 take,
  input  wire logic [DIM_W-1:0]     pixel_index,
  output front_t                    front_o
);

  logic [DIM_W-1:0] src_r, scl_r, tgt_r;

  logic               v1_r;
  logic               zero1_r, badidx1_r;
  logic [DIM_W:0]     odd1_r;
  logic [2*DIM_W-1:0] prod1_r;
  logic [DIM_W-1:0]   tgt1_r, scl1_r;

  front_t f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= RST_SOURCE_LENGTH;
      scl_r <= RST_SCALE_FACTOR;
      tgt_r <= RST_TARGET_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_LENGTH: src_r <= cfg_wdata;
        CFG_SCALE_FACTOR:  scl_r <= cfg_wdata;
        CFG_TARGET_LENGTH: tgt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    odd1_r    <= {pixel_index, 1'b1};
    prod1_r   <= src_r * scl_r;
    zero1_r   <= (src_r == '0) || (scl_r == '0) || (tgt_r == '0);
    badidx1_r <= pixel_index >= tgt_r;
    tgt1_r    <= tgt_r;
    scl1_r    <= scl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_r.valid <= 1'b0;
    end else begin
      f2_r.valid <= v1_r;
    end
    if (zero1_r || (prod1_r[2*DIM_W-1:DIM_W] != '0)) begin
      f2_r.status <= ST_BAD_CONFIG;
    end else if (badidx1_r) begin
      f2_r.status <= ST_BAD_INDEX;
    end else begin
      f2_r.status <= ST_OK;
    end
    f2_r.num   <= {(2*DIM_W+1)'(odd1_r) * (2*DIM_W+1)'(prod1_r[DIM_W-1:0]),
                   {FRAC_BITS{1'b0}}};
    f2_r.den   <= {tgt1_r, 1'b0};
    f2_r.vsize <= prod1_r[DIM_W-1:0];
    f2_r.scl   <= scl1_r;
  end

  assign front_o = f2_r;

endmodule
`default_nettype wire

>>> sv/sbsp_back.sv
// Back end: pipelined position divide, clamp, and pipelined divide by scale.
`default_nettype none
module sbsp_back
  import sbsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  front_t    front_i,
  output logic      res_valid,
  output res_t      res_o
);

  typedef struct packed {
    logic [1:0]       status;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic [DIM_W-1:0] vsize;
    logic [DIM_W-1:0] scl;
  } qstage_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       weight;
    logic             has_next;
    logic [DIM_W-1:0] rem;
    logic [DIM_W-1:0] low;
    logic [DIM_W-1:0] quo;
    logic [DIM_W-1:0] scl;
  } sstage_t;

  logic    qv_r [QSTAGES];
  qstage_t qs_r [QSTAGES];
  logic    sv_r [SSTAGES];
  sstage_t ss_r [SSTAGES];

  qstage_t q_in;
  always_comb begin
    q_in.status = front_i.status;
    q_in.rem    = DEN_W'(front_i.num[NUM_W-1:QUO_W]);
    q_in.low    = front_i.num[QUO_W-1:0];
    q_in.quo    = '0;
    q_in.den    = front_i.den;
    q_in.vsize  = front_i.vsize;
    q_in.scl    = front_i.scl;
  end

  genvar g;
  generate
    for (g = 0; g < QSTAGES; g++) begin : g_qdiv
      qstage_t        src;
      logic [DEN_W:0] s0, s1;
      qstage_t        nxt;
      logic           vin;
      if (g == 0) begin : g_first
        assign src = q_in;
        assign vin = front_i.valid;
      end else begin : g_rest
        assign src = qs_r[g-1];
        assign vin = qv_r[g-1];
      end
      always_comb begin
        s0 = qstep(src.rem, src.low[QUO_W-1], src.den);
        s1 = qstep(s0[DEN_W-1:0], src.low[QUO_W-2], src.den);
        nxt = src;
        nxt.rem = s1[DEN_W-1:0];
        nxt.low = {src.low[QUO_W-3:0], 2'b00};
        nxt.quo = {src.quo[QUO_W-3:0], s0[DEN_W], s1[DEN_W]};
      end
      always_ff @(posedge clk) begin
        if (!rst_n) qv_r[g] <= 1'b0;
        else        qv_r[g] <= vin;
      end
      always_ff @(posedge clk) begin
        qs_r[g] <= nxt;
      end
    end
  endgenerate

  // clamp the sample position to the virtual range and split it
  qstage_t          ql;
  logic [QUO_W-1:0] pos, top;
  logic [DIM_W-1:0] first;
  sstage_t          s_in;
  always_comb begin
    ql  = qs_r[QSTAGES-1];
    pos = (ql.quo < STEP_HALF) ? '0 : ql.quo - STEP_HALF;
    top = QUO_W'({ql.vsize - 16'd1, {FRAC_BITS{1'b0}}});
    if (pos > top) pos = top;
    first = pos[FRAC_BITS +: DIM_W];
    s_in.status   = ql.status;
    s_in.weight   = pos[FRAC_BITS-1:0];
    s_in.has_next = ({1'b0, first} + 17'd1) < {1'b0, ql.vsize};
    s_in.rem      = '0;
    s_in.low      = first;
    s_in.quo      = '0;
    s_in.scl      = ql.scl;
  end

  generate
    for (g = 0; g < SSTAGES; g++) begin : g_sdiv
      sstage_t        src;
      logic [DIM_W:0] s0, s1;
      sstage_t        nxt;
      logic           vin;
      if (g == 0) begin : g_first
        assign src = s_in;
        assign vin = qv_r[QSTAGES-1];
      end else begin : g_rest
        assign src = ss_r[g-1];
        assign vin = sv_r[g-1];
      end
      always_comb begin
        s0 = sstep(src.rem, src.low[DIM_W-1], src.scl);
        s1 = sstep(s0[DIM_W-1:0], src.low[DIM_W-2], src.scl);
        nxt = src;
        nxt.rem = s1[DIM_W-1:0];
        nxt.low = {src.low[DIM_W-3:0], 2'b00};
        nxt.quo = {src.quo[DIM_W-3:0], s0[DIM_W], s1[DIM_W]};
      end
      always_ff @(posedge clk) begin
        if (!rst_n) sv_r[g] <= 1'b0;
        else        sv_r[g] <= vin;
      end
      always_ff @(posedge clk) begin
        ss_r[g] <= nxt;
      end
    end
  endgenerate

  // far pixel crosses into the next source pixel when the remainder wraps
  sstage_t sl;
  always_comb begin
    sl = ss_r[SSTAGES-1];
    res_o.status = sl.status;
    if (sl.status == ST_OK) begin
      res_o.near_index   = sl.quo;
      res_o.far_index    = (sl.has_next && ({1'b0, sl.rem} + 17'd1 == {1'b0, sl.scl})) ?
                           sl.quo + 16'd1 : sl.quo;
      res_o.blend_weight = sl.weight;
    end else begin
      res_o.near_index   = '0;
      res_o.far_index    = '0;
      res_o.blend_weight = '0;
    end
  end

  assign res_valid = sv_r[SSTAGES-1];

endmodule
`default_nettype wire

>>> sv/sbsp_queue.sv
// Result queue; depth must be a power of two.
`default_nettype none
module sbsp_queue
  import sbsp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  res_t      wdata,
  input  wire logic rd,
  output logic      empty,
  output res_t      rdata
);

  localparam int AW = $clog2(DEPTH);

  res_t            mem [DEPTH];
  res_t            head_r;
  logic            head_v_r;
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     occ_r;
  logic            head_free, from_mem, from_in, to_mem;

  // head register holds the oldest word, the store holds the rest
  assign head_free = !head_v_r || rd;
  assign from_mem  = head_free && (occ_r != '0);
  assign from_in   = head_free && (occ_r == '0) && wr;
  assign to_mem    = wr && !from_in;

  always_ff @(posedge clk) begin
    if (to_mem) mem[wp_r] <= wdata;
    if (from_mem) begin
      head_r <= mem[rp_r];
    end else if (from_in) begin
      head_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      occ_r    <= '0;
      head_v_r <= 1'b0;
    end else begin
      if (to_mem)    wp_r <= wp_r + 1'b1;
      if (from_mem)  rp_r <= rp_r + 1'b1;
      occ_r <= occ_r + (AW+1)'(to_mem) - (AW+1)'(from_mem);
      if (head_free) head_v_r <= from_mem || from_in;
    end
  end

  assign empty = !head_v_r;
  assign rdata = head_r;

endmodule
`default_nettype wire

>>> sv/sharp_bilinear_sample_points_unit.sv
// Path: a pushed word runs through the front, both divide pipelines and the queue.
// Throughput: one word per cycle unless full; the divide stages each take two bits.
// Words in flight plus waiting results are bounded by DEPTH (full when reached).
// Reset (synchronous, rst_n low): registers to 128 / 1 / 128, pipeline and queue empty.
`default_nettype none
module sharp_bilinear_sample_points_unit
  import sbsp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [DIM_W-1:0]     in_pixel_index,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [DIM_W-1:0]          out_near_index,
  output logic [DIM_W-1:0]          out_far_index,
  output logic [4:0]                out_blend_weight,
  output logic [1:0]                out_status
);

  localparam int CW = $clog2(DEPTH) + 1;

  logic          take, give;
  logic [CW-1:0] cnt_r;
  front_t        front;
  logic          res_valid;
  res_t          res, head;

  // credit count covers the pipeline too, so the queue never overflows
  assign full = (cnt_r == CW'(DEPTH));
  assign take = push && !full;
  assign give = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_r + CW'(take) - CW'(give);
  end

  sbsp_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .take, .pixel_index(in_pixel_index), .front_o(front)
  );

  sbsp_back u_back (
    .clk, .rst_n, .front_i(front), .res_valid, .res_o(res)
  );

  sbsp_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst_n, .wr(res_valid), .wdata(res), .rd(give), .empty, .rdata(head)
  );

  assign out_near_index   = head.near_index;
  assign out_far_index    = head.far_index;
  assign out_blend_weight = head.blend_weight;
  assign out_status       = head.status;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("credit count overrun");
  a_head_counted: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> cnt_r != '0) else $error("result without credit");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    take && !give |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count missed a word");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status != ST_OK |-> out_near_index == '0 && out_blend_weight == '0)
    else $error("error word carries data");
`endif

endmodule
`default_nettype wire
